// ===== hw/rtl/event_lifecycle_checker_unit_macros.svh =====
// Assertion macros for the lifecycle checker
`ifndef EVENT_LIFECYCLE_CHECKER_UNIT_MACROS_SVH
`define EVENT_LIFECYCLE_CHECKER_UNIT_MACROS_SVH

// same-cycle implication
`define ELC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lifecycle checker assertion failed");

// next-cycle implication
`define ELC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lifecycle checker assertion failed");

`endif

// ===== hw/rtl/elc_pkg.sv =====
package elc_pkg;

    localparam int IDS_PER_CLASS_DEF = 16;
    localparam int NUM_CLASSES       = 4;

    localparam logic [3:0] K_BAD_ID     = 4'd0;
    localparam logic [3:0] K_BACK_TIME  = 4'd1;
    localparam logic [3:0] K_USE_OUT    = 4'd2;
    localparam logic [3:0] K_DUP_USE    = 4'd3;
    localparam logic [3:0] K_DUP_START  = 4'd4;
    localparam logic [3:0] K_TERM_NOST  = 4'd5;
    localparam logic [3:0] K_DUP_TERM   = 4'd6;
    localparam logic [3:0] K_MISS_TERM  = 4'd7;
    localparam logic [3:0] K_CLEAN_DONE = 4'd8;

    localparam logic [1:0] ROLE_START = 2'd1;
    localparam logic [1:0] ROLE_TERM  = 2'd2;
    localparam logic [1:0] ROLE_USAGE = 2'd3;
    localparam logic [1:0] CLS_INVOC  = 2'd3;

    localparam logic [1:0] OSEL_EV  = 2'd0;
    localparam logic [1:0] OSEL_OUT = 2'd1;
    localparam logic [1:0] OSEL_END = 2'd2;

    typedef struct packed {
        logic [1:0]  sc;
        logic [1:0]  tc;
        logic [31:0] fe;
    } t_word;

    localparam int WORD_W = $bits(t_word);

    typedef struct packed {
        logic       cap;
        logic       eval;
        logic       pop;
        logic       sw_start;
        logic       sw_rd;
        logic       sw_chk;
        logic       k_inc;
        logic       clear;
        logic [1:0] osel;
    } t_cmd;

    typedef struct packed {
        logic ev_any;
        logic mask_last;
        logic found;
        logic have;
        logic k_last;
    } t_sts;

    function automatic logic [1:0] sat2(input logic [1:0] v);
        return (v >= 2'd2) ? 2'd2 : v + 2'd1;
    endfunction

endpackage

// ===== hw/rtl/elc_in_if.sv =====
interface elc_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [1:0]  event_role;
    logic [1:0]  lifecycle_class;
    logic [3:0]  identity;
    logic [31:0] event_id;
    logic [62:0] time_offset;

    modport source (output valid, command, event_role, lifecycle_class, identity, event_id,
                    time_offset, input ready);
    modport sink (input valid, command, event_role, lifecycle_class, identity, event_id,
                  time_offset, output ready);
endinterface

// ===== hw/rtl/elc_out_if.sv =====
interface elc_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  issue_kind;
    logic [31:0] issue_event;
    logic [31:0] issue_identity;
    logic [1:0]  issue_class;
    logic        last_of_run;

    modport source (output valid, issue_kind, issue_event, issue_identity, issue_class,
                    last_of_run, input ready);
    modport sink (input valid, issue_kind, issue_event, issue_identity, issue_class,
                  last_of_run, output ready);
endinterface

// ===== hw/rtl/elc_ram.sv =====
module elc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== hw/rtl/elc_datapath.sv =====
module elc_datapath import elc_pkg::*; #(
    parameter int IDS_PER_CLASS = IDS_PER_CLASS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [1:0]  i_event_role,
    input  logic [1:0]  i_lifecycle_class,
    input  logic [3:0]  i_identity,
    input  logic [31:0] i_event_id,
    input  logic [62:0] i_time_offset,
    output logic [3:0]  o_issue_kind,
    output logic [31:0] o_issue_event,
    output logic [31:0] o_issue_identity,
    output logic [1:0]  o_issue_class,
    output logic        o_last_of_run
);
    localparam int NUM_KEYS = NUM_CLASSES * IDS_PER_CLASS;
    localparam int KW       = $clog2(NUM_KEYS);
    localparam int UW       = (IDS_PER_CLASS > 1) ? $clog2(IDS_PER_CLASS) : 1;
    localparam logic [3:0] ID_LAST = 4'(IDS_PER_CLASS - 1);

    logic [1:0]  r_role, r_cls;
    logic [3:0]  r_ident;
    logic [31:0] r_ev;
    logic [62:0] r_t;
    logic [KW-1:0] r_key;
    logic        r_inr;
    logic [31:0] r_pos, r_psnap;
    logic [62:0] r_prev;
    logic [NUM_KEYS-1:0] r_kv;
    logic [1:0]  r_usage [IDS_PER_CLASS];
    logic [6:0]  r_mask, n_mask;
    logic [1:0]  r_sw_cls;
    logic [3:0]  r_sw_id;
    logic        r_have;
    logic [31:0] r_pd_ev, r_out_ev;
    logic [3:0]  r_pd_id, r_out_id;
    logic [1:0]  r_pd_cls, r_out_cls;

    logic [1:0]    in_cls;
    logic [KW-1:0] in_key, sw_key, raddr;
    logic          in_inr;
    t_word         rd, wr;
    logic          ram_we;
    logic          v;
    logic [1:0]    sc, tc, sc_n, tc_n, uc_n;
    logic [31:0]   fe;
    logic          is_use, is_life, found;
    logic [2:0]    low;
    logic [6:0]    mask_rest;

    assign in_cls = (i_event_role == ROLE_USAGE) ? CLS_INVOC : i_lifecycle_class;
    assign in_key = KW'(in_cls) * KW'(IDS_PER_CLASS) + KW'(i_identity);
    assign in_inr = {1'b0, i_identity} < 5'(IDS_PER_CLASS);
    assign sw_key = KW'(r_sw_cls) * KW'(IDS_PER_CLASS) + KW'(r_sw_id);
    assign raddr  = i_cmd.sw_rd ? sw_key : in_key;

    elc_ram #(.WIDTH(WORD_W), .DEPTH(NUM_KEYS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_key),
        .i_wdata(wr),
        .i_raddr(raddr),
        .o_rdata(rd)
    );

    // check of one event
    always_comb begin
        v       = r_kv[r_key];
        sc      = v ? rd.sc : 2'd0;
        tc      = v ? rd.tc : 2'd0;
        fe      = v ? rd.fe : r_ev;
        is_use  = r_inr && (r_role == ROLE_USAGE);
        is_life = r_inr && ((r_role == ROLE_START) || (r_role == ROLE_TERM));
        sc_n    = (r_role == ROLE_START) ? sat2(sc) : sc;
        tc_n    = (r_role == ROLE_TERM) ? sat2(tc) : tc;
        uc_n    = sat2(r_usage[r_ident[UW-1:0]]);
        wr      = '{sc: sc_n, tc: tc_n, fe: fe};
        ram_we  = i_cmd.eval && is_life;
        n_mask    = '0;
        n_mask[0] = (r_ev != r_pos);
        n_mask[1] = (r_pos != 32'd0) && (r_t < r_prev);
        n_mask[2] = is_use && ((sc == 2'd0) || (tc != 2'd0));
        n_mask[3] = is_use && (uc_n > 2'd1);
        n_mask[4] = is_life && (r_role == ROLE_START) && (sc_n > 2'd1);
        n_mask[5] = is_life && (r_role == ROLE_TERM) && (sc == 2'd0);
        n_mask[6] = is_life && (r_role == ROLE_TERM) && (sc != 2'd0) && (tc_n > 2'd1);
    end

    assign found = r_kv[sw_key] && (rd.sc != 2'd0) && (rd.tc == 2'd0);

    always_comb begin
        low = 3'd0;
        for (int i = 6; i >= 0; i--) begin
            if (r_mask[i]) begin
                low = 3'(i);
            end
        end
    end
    assign mask_rest = r_mask & (r_mask - 7'd1);

    assign o_sts = '{ev_any: |n_mask, mask_last: (mask_rest == 7'd0), found: found,
                     have: r_have, k_last: (r_sw_cls == CLS_INVOC) && (r_sw_id == ID_LAST)};

    always_comb begin
        o_last_of_run = 1'b1;
        unique case (i_cmd.osel)
            OSEL_EV: begin
                o_issue_kind     = {1'b0, low};
                o_issue_event    = r_ev;
                o_issue_identity = (low < 3'd2) ? r_psnap : 32'(r_ident);
                o_issue_class    = (low < 3'd2) ? 2'd0 : (low < 3'd4) ? CLS_INVOC : r_cls;
                o_last_of_run    = (mask_rest == 7'd0);
            end
            OSEL_OUT: begin
                o_issue_kind     = K_MISS_TERM;
                o_issue_event    = r_out_ev;
                o_issue_identity = 32'(r_out_id);
                o_issue_class    = r_out_cls;
                o_last_of_run    = 1'b0;
            end
            default: begin
                o_issue_kind     = r_have ? K_MISS_TERM : K_CLEAN_DONE;
                o_issue_event    = r_have ? r_pd_ev : 32'd0;
                o_issue_identity = r_have ? 32'(r_pd_id) : 32'd0;
                o_issue_class    = r_have ? r_pd_cls : 2'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_role  <= i_event_role;
            r_cls   <= i_lifecycle_class;
            r_ident <= i_identity;
            r_ev    <= i_event_id;
            r_t     <= i_time_offset;
            r_key   <= in_key;
            r_inr   <= in_inr;
        end
        if (i_cmd.eval) begin
            r_psnap <= r_pos;
        end
        if (i_cmd.sw_chk && found) begin
            r_out_ev  <= r_pd_ev;
            r_out_id  <= r_pd_id;
            r_out_cls <= r_pd_cls;
            r_pd_ev   <= rd.fe;
            r_pd_id   <= r_sw_id;
            r_pd_cls  <= r_sw_cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_pos  <= '0;
            r_prev <= '0;
            r_kv   <= '0;
            r_mask <= '0;
            r_have <= 1'b0;
            for (int i = 0; i < IDS_PER_CLASS; i++) begin
                r_usage[i] <= 2'd0;
            end
        end else begin
            if (i_cmd.eval) begin
                r_mask <= n_mask;
                r_prev <= r_t;
                if (r_pos != '1) begin
                    r_pos <= r_pos + 32'd1;
                end
                if (is_use) begin
                    r_usage[r_ident[UW-1:0]] <= uc_n;
                end
                if (is_life) begin
                    r_kv[r_key] <= 1'b1;
                end
            end else if (i_cmd.pop) begin
                r_mask <= mask_rest;
            end
            if (i_cmd.sw_chk && found) begin
                r_have <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.sw_start) begin
            r_sw_cls <= '0;
            r_sw_id  <= '0;
        end else if (i_cmd.k_inc) begin
            if (r_sw_id == ID_LAST) begin
                r_sw_id  <= '0;
                r_sw_cls <= r_sw_cls + 2'd1;
            end else begin
                r_sw_id <= r_sw_id + 4'd1;
            end
        end
    end
endmodule

// ===== hw/rtl/elc_ctrl.sv =====
`include "event_lifecycle_checker_unit_macros.svh"

module elc_ctrl import elc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_command,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd,
    input  t_sts i_sts
);
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EV_CHK = 3'd1;
    localparam logic [2:0] S_EV_OUT = 3'd2;
    localparam logic [2:0] S_SW_RD  = 3'd3;
    localparam logic [2:0] S_SW_CHK = 3'd4;
    localparam logic [2:0] S_SW_OUT = 3'd5;
    localparam logic [2:0] S_SW_END = 3'd6;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_cmd.osel  = OSEL_EV;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    if (i_command) begin
                        o_cmd.sw_start = 1'b1;
                        n_state        = S_SW_RD;
                    end else begin
                        n_state = S_EV_CHK;
                    end
                end
            end
            S_EV_CHK: begin
                o_cmd.eval = 1'b1;
                n_state    = i_sts.ev_any ? S_EV_OUT : S_IDLE;
            end
            S_EV_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.pop = 1'b1;
                    if (i_sts.mask_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SW_RD: begin
                o_cmd.sw_rd = 1'b1;
                n_state     = S_SW_CHK;
            end
            S_SW_CHK: begin
                o_cmd.sw_chk = 1'b1;
                if (i_sts.found && i_sts.have) begin
                    n_state = S_SW_OUT;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state     = i_sts.k_last ? S_SW_END : S_SW_RD;
                end
            end
            S_SW_OUT: begin
                o_out_valid = 1'b1;
                o_cmd.osel  = OSEL_OUT;
                if (i_out_ready) begin
                    o_cmd.k_inc = 1'b1;
                    n_state     = i_sts.k_last ? S_SW_END : S_SW_RD;
                end
            end
            S_SW_END: begin
                o_out_valid = 1'b1;
                o_cmd.osel  = OSEL_END;
                if (i_out_ready) begin
                    o_cmd.clear = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `ELC_ASSERT_NOW(a_no_overlap, o_in_ready, !o_out_valid)
    `ELC_ASSERT_NEXT(a_eval_follows_event, o_cmd.cap && !i_command, o_cmd.eval)
    `ELC_ASSERT_NEXT(a_end_clears, o_cmd.clear, o_in_ready)
endmodule

// ===== hw/rtl/event_lifecycle_checker_unit.sv =====
// Event lifecycle checker.
// i_evt (sink) takes one beat per event or finish command; o_iss (source) gives
// issue beats, last_of_run marking the final beat caused by an input beat.
// An event is checked after acceptance (key store read, then check and
// write-back); its issues then follow one per cycle while o_iss.ready is high.
// An event with no issues gives no beat, and the unit then returns to idle.
// Finish walks all 4*IDS_PER_CLASS keys, each read and then checked through the
// single read port of the key store, giving missing-terminal beats as found;
// then position, timestamp, key valid bits and usage counts are cleared.
// One input beat is handled at a time: i_evt.ready is high only while no issue
// beats remain for the previous input.
// A stall on o_iss holds the current beat and the walk.
// Reset clears the position, timestamp, key valid bits and usage counts at once;
// the key store needs no clearing pass.
module event_lifecycle_checker_unit import elc_pkg::*; #(
    parameter int IDS_PER_CLASS = IDS_PER_CLASS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    elc_in_if.sink     i_evt,
    elc_out_if.source  o_iss
);
    t_cmd cmd;
    t_sts sts;

    elc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_evt.valid),
        .i_command  (i_evt.command),
        .o_in_ready (i_evt.ready),
        .o_out_valid(o_iss.valid),
        .i_out_ready(o_iss.ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    elc_datapath #(.IDS_PER_CLASS(IDS_PER_CLASS)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_event_role     (i_evt.event_role),
        .i_lifecycle_class(i_evt.lifecycle_class),
        .i_identity       (i_evt.identity),
        .i_event_id       (i_evt.event_id),
        .i_time_offset    (i_evt.time_offset),
        .o_issue_kind     (o_iss.issue_kind),
        .o_issue_event    (o_iss.issue_event),
        .o_issue_identity (o_iss.issue_identity),
        .o_issue_class    (o_iss.issue_class),
        .o_last_of_run    (o_iss.last_of_run)
    );
endmodule
